FILE: rtl/plcl_pkg.sv
// ----------------------------------------------------------------------------
// plcl_pkg: shared constants for the curve lookup block
// Field widths, status codes and Q16 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package plcl_pkg;

  localparam int unsigned MAX_NODES_DEF = 32;

  localparam int unsigned TENOR_W = 16;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned NODE_W  = TENOR_W + RATE_W;
  localparam int unsigned W_W     = 17;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned IN_DW   = 72;
  localparam int unsigned OUT_DW  = 88;

  localparam logic [W_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BELOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABOVE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EXACT  = 3'd4;
  localparam logic [STAT_W-1:0] ST_INTERP = 3'd5;
  localparam logic [STAT_W-1:0] ST_LOADED = 3'd6;

endpackage

`default_nettype wire

FILE: rtl/plcl_mem.sv
// ----------------------------------------------------------------------------
// plcl_mem: curve node memory
// One write port, one read port, registered read data; {rate, tenor}.
// ----------------------------------------------------------------------------
`default_nettype none

module plcl_mem
  import plcl_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_NODES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire  logic              clk_i,
  input  wire  logic              we_i,
  input  wire  logic [AW-1:0]     waddr_i,
  input  wire  logic [NODE_W-1:0] wdata_i,
  input  wire  logic [AW-1:0]     raddr_i,
  output logic       [NODE_W-1:0] rdata_o
);

  logic [NODE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/plcl_div.sv
// ----------------------------------------------------------------------------
// plcl_div: serial Q16 fraction divider
// floor(num * 2^16 / den) for num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plcl_div
  import plcl_pkg::*;
(
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               start_i,
  input  wire  logic [TENOR_W-1:0] num_i,
  input  wire  logic [TENOR_W-1:0] den_i,
  output logic                     done_o,
  output logic [W_W-1:0]           quo_o
);

  logic [TENOR_W:0]   rem_q;
  logic [TENOR_W-1:0] den_q;
  logic [4:0]         cnt_q;
  logic               busy_q;
  logic [TENOR_W:0]   diff;
  logic               ge;

  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(W_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_o <= '0;
    end else if (busy_q) begin
      // remainder stays below den, so the shifted value fits
      rem_q <= {diff[TENOR_W-1:0], 1'b0};
      quo_o <= {quo_o[W_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/piecewise_linear_curve_lookup_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_core: zero-rate curve lookup with Q16 buckets
// The search alternates a read step and a compare step; the serial divider
//   sets the tail of an interpolated query, and is skipped when the weight is
//   forced to zero. One item at a time.
// Reset clears entry_count and the control state; the node memory is
//   undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_curve_lookup_core
  import plcl_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  // configuration: entry_count
  input  wire  logic              cfg_we_i,
  input  wire  logic [CNT_W-1:0]  cfg_wdata_i,
  // input stream
  input  wire  logic              s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // [4:0] entry_index, [20:5] node_tenor, [52:21] node_rate, [68:53] maturity
  input  wire  logic [IN_DW-1:0]  s_axis_tdata_i,
  // [0] mode
  input  wire  logic              s_axis_tuser_i,
  // output stream
  output logic                    m_axis_tvalid_o,
  input  wire  logic              m_axis_tready_i,
  // [31:0] rate_out, [33:32] bucket_count, [49:34] lower_node_tenor,
  // [65:50] upper_node_tenor, [82:66] upper_weight
  output logic [OUT_DW-1:0]       m_axis_tdata_o,
  // [2:0] status
  output logic [STAT_W-1:0]       m_axis_tuser_o
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_IDX   = 4'd5;
  localparam logic [3:0] S_LOW   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CNT_W-1:0] entry_count_q;

  // input fields
  logic [IDX_W-1:0]   in_idx;
  logic [TENOR_W-1:0] in_tenor;
  logic [RATE_W-1:0]  in_rate;
  logic [TENOR_W-1:0] in_mat;
  assign in_idx   = s_axis_tdata_i[4:0];
  assign in_tenor = s_axis_tdata_i[20:5];
  assign in_rate  = s_axis_tdata_i[52:21];
  assign in_mat   = s_axis_tdata_i[68:53];

  logic in_xfer;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // nodes in use, clipped to the memory depth
  logic [CW-1:0] n;
  assign n = (32'(entry_count_q) > MAX_NODES) ? CW'(MAX_NODES) : CW'(entry_count_q);

  // memory
  logic              mem_we;
  logic [AW-1:0]     raddr;
  logic [NODE_W-1:0] rdata;
  logic [TENOR_W-1:0] rd_tenor;
  logic [RATE_W-1:0]  rd_rate;
  assign mem_we   = in_xfer && !s_axis_tuser_i && (32'(in_idx) < MAX_NODES);
  assign rd_tenor = rdata[TENOR_W-1:0];
  assign rd_rate  = rdata[NODE_W-1:TENOR_W];

  plcl_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(in_idx)),
    .wdata_i ({in_rate, in_tenor}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // search and datapath registers
  logic [TENOR_W-1:0] mat_q;
  logic [CW-1:0]      lo_q, hi_q;
  logic [AW-1:0]      idx_q;
  logic [TENOR_W-1:0] th_q;
  logic [RATE_W-1:0]  rh_q, rl_q;
  logic [W_W-1:0]     w_q;
  logic signed [50:0] prod_q;

  logic [CW:0]   lohi_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] sidx;
  logic [CW-1:0] n_m1;
  assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = lohi_sum[CW:1];
  assign n_m1     = n - 1'b1;
  assign sidx     = (lo_q >= n) ? n_m1 : lo_q;

  // divider
  logic           div_start, div_done;
  logic [W_W-1:0] div_quo;
  logic           no_div;
  assign no_div    = (rd_tenor >= mat_q) || (th_q <= rd_tenor);
  assign div_start = (state_q == S_LOW) && !no_div;

  plcl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mat_q - rd_tenor),
    .den_i   (th_q - rd_tenor),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // interpolation arithmetic
  logic signed [32:0] rdiff;
  logic signed [50:0] prod_sh;
  assign rdiff   = $signed({rh_q[RATE_W-1], rh_q}) - $signed({rl_q[RATE_W-1], rl_q});
  assign prod_sh = prod_q >>> 16;  // floor toward minus infinity

  // result holding registers
  logic [RATE_W-1:0]  res_rate_q;
  logic [STAT_W-1:0]  res_stat_q;
  logic [1:0]         res_cnt_q;
  logic [TENOR_W-1:0] res_lo_q, res_hi_q;

  logic out_free;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  // next state and read address
  always_comb begin
    state_d = state_q;
    raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (!s_axis_tuser_i || n == '0 || in_mat == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (mat_q < rd_tenor) begin
          state_d = S_OUT;
        end else begin
          raddr   = n_m1[AW-1:0];
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = (mat_q > rd_tenor) ? S_OUT : S_SRCH;
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          raddr   = mid[AW-1:0];
          state_d = S_PROBE;
        end else begin
          raddr   = sidx[AW-1:0];
          state_d = S_IDX;
        end
      end
      S_PROBE: state_d = S_SRCH;
      S_IDX: begin
        if (rd_tenor == mat_q || idx_q == '0) begin
          state_d = S_OUT;
        end else begin
          raddr   = idx_q - 1'b1;
          state_d = S_LOW;
        end
      end
      S_LOW:   state_d = no_div ? S_MUL : S_DIV;
      S_DIV:   state_d = div_done ? S_MUL : S_DIV;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_OUT;
      S_OUT:   state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mat_q      <= in_mat;
        res_rate_q <= '0;
        res_cnt_q  <= '0;
        res_lo_q   <= '0;
        res_hi_q   <= '0;
        w_q        <= '0;
        if (!s_axis_tuser_i) begin
          res_stat_q <= ST_LOADED;
        end else if (n == '0) begin
          res_stat_q <= ST_EMPTY;
        end else begin
          res_stat_q <= ST_ZERO;
        end
      end
      S_FIRST: begin
        // single-node answer, used if below
        res_rate_q <= rd_rate;
        res_stat_q <= ST_BELOW;
        res_cnt_q  <= 2'd1;
        res_lo_q   <= rd_tenor;
        res_hi_q   <= rd_tenor;
        w_q        <= Q16_ONE;
      end
      S_LAST: begin
        res_rate_q <= rd_rate;
        res_stat_q <= ST_ABOVE;
        res_lo_q   <= rd_tenor;
        res_hi_q   <= rd_tenor;
        lo_q       <= '0;
        hi_q       <= n;
      end
      S_SRCH: begin
        idx_q <= (lo_q < hi_q) ? mid[AW-1:0] : sidx[AW-1:0];
      end
      S_PROBE: begin
        if (rd_tenor < mat_q) begin
          lo_q <= CW'({1'b0, idx_q}) + 1'b1;
        end else begin
          hi_q <= CW'({1'b0, idx_q});
        end
      end
      S_IDX: begin
        th_q       <= rd_tenor;
        rh_q       <= rd_rate;
        res_rate_q <= rd_rate;
        res_stat_q <= ST_EXACT;
        res_lo_q   <= rd_tenor;
        res_hi_q   <= rd_tenor;
      end
      S_LOW: begin
        rl_q       <= rd_rate;
        res_stat_q <= ST_INTERP;
        res_cnt_q  <= 2'd2;
        res_lo_q   <= rd_tenor;
        res_hi_q   <= th_q;
        w_q        <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          w_q <= (div_quo > Q16_ONE) ? Q16_ONE : div_quo;
        end
      end
      S_MUL: begin
        prod_q <= rdiff * $signed({1'b0, w_q});
      end
      S_ADD: begin
        res_rate_q <= rl_q + prod_sh[RATE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // output register parts the result from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      m_axis_tvalid_o <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_axis_tvalid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      m_axis_tdata_o <= {5'd0, w_q, res_hi_q, res_lo_q, res_cnt_q, res_rate_q};
      m_axis_tuser_o <= res_stat_q;
    end
  end

  // checks
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_hi_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (hi_q <= n && lo_q <= hi_q))
    else $error("search bounds out of range");

  a_weight_q16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> w_q <= Q16_ONE)
    else $error("interpolation weight above one");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_IDLE)
    else $error("node write while a query is reading");

endmodule

`default_nettype wire

FILE: tb/piecewise_linear_curve_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_core_tb: self-checking bench for the curve lookup
// Loads curve nodes, sweeps entry_count settings and checks every query and
// load result field by field against an in-bench curve predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_curve_lookup_core_tb
  import plcl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   NODES      = 32;
  localparam int   DRAIN_CYC  = 64;   // longer than the slowest query

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [STAT_W-1:0]  status;
    logic [1:0]         buckets;
    logic [TENOR_W-1:0] lo_tenor;
    logic [TENOR_W-1:0] hi_tenor;
    logic [W_W-1:0]     weight;
  } lookup_t;

  // Curve predictor plus the queue of lookups still owed by the block.
  class curve_scoreboard;
    logic [TENOR_W-1:0] tenor_tab [NODES];
    logic [RATE_W-1:0]  rate_tab [NODES];
    int unsigned        node_cnt;
    lookup_t            owed_q[$];
    int                 errors;
    int                 status_seen [8];

    function new();
      node_cnt = 0;
      errors   = 0;
      foreach (tenor_tab[i]) begin
        tenor_tab[i] = '0;
        rate_tab[i]  = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      node_cnt = (v > NODES) ? NODES : v;
    endfunction

    function void note_item(logic mode, logic [IDX_W-1:0] idx, logic [TENOR_W-1:0] tenor,
                            logic [RATE_W-1:0] rate, logic [TENOR_W-1:0] mat);
      lookup_t     r;
      int unsigned lo, hi, mid, k;
      longint      rl, rh, w, tl, th;
      r = '0;
      if (mode == MODE_LOAD) begin
        tenor_tab[idx] = tenor;
        rate_tab[idx]  = rate;
        r.status = ST_LOADED;
      end else if (node_cnt == 0) begin
        r.status = ST_EMPTY;
      end else if (mat == 0) begin
        r.status = ST_ZERO;
      end else if (mat < tenor_tab[0]) begin
        r = '{rate_tab[0], ST_BELOW, 2'd1, tenor_tab[0], tenor_tab[0], Q16_ONE};
      end else if (mat > tenor_tab[node_cnt-1]) begin
        k = node_cnt - 1;
        r = '{rate_tab[k], ST_ABOVE, 2'd1, tenor_tab[k], tenor_tab[k], Q16_ONE};
      end else begin
        // lower-bound search: first node not below the maturity
        lo = 0;
        hi = node_cnt;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (tenor_tab[mid] < mat) lo = mid + 1;
          else hi = mid;
        end
        k = (lo >= node_cnt) ? node_cnt - 1 : lo;
        if (tenor_tab[k] == mat || k == 0) begin
          r = '{rate_tab[k], ST_EXACT, 2'd1, tenor_tab[k], tenor_tab[k], Q16_ONE};
        end else begin
          tl = tenor_tab[k-1];
          th = tenor_tab[k];
          rl = $signed(rate_tab[k-1]);
          rh = $signed(rate_tab[k]);
          // misordered neighbors give zero weight
          if (tl >= mat || th <= tl) w = 0;
          else w = ((longint'(mat) - tl) << 16) / (th - tl);
          if (w > 65536) w = 65536;
          r.rate     = RATE_W'(rl + (((rh - rl) * w) >>> 16));
          r.status   = ST_INTERP;
          r.buckets  = 2'd2;
          r.lo_tenor = TENOR_W'(tl);
          r.hi_tenor = TENOR_W'(th);
          r.weight   = W_W'(w);
        end
      end
      owed_q = {owed_q, r};
    endfunction

    function void check_result(logic [OUT_DW-1:0] data, logic [STAT_W-1:0] user);
      lookup_t got, exp_r;
      got = '{data[31:0], user, data[33:32], data[49:34], data[65:50], data[82:66]};
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result status %0d", user);
        return;
      end
      exp_r = owed_q.pop_front();
      status_seen[exp_r.status]++;
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: mismatch exp rate %h st %0d cnt %0d lo %0d hi %0d w %0d",
                   exp_r.rate, exp_r.status, exp_r.buckets, exp_r.lo_tenor,
                   exp_r.hi_tenor, exp_r.weight);
          $display("       got rate %h st %0d cnt %0d lo %0d hi %0d w %0d",
                   got.rate, got.status, got.buckets, got.lo_tenor,
                   got.hi_tenor, got.weight);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_DW-1:0]  s_axis_tdata_i = '0;
  logic              s_axis_tuser_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata_o;
  logic [STAT_W-1:0] m_axis_tuser_o;

  curve_scoreboard sb = new();

  int send_gap_pct = 0;   // chance the sender idles before an item
  int stall_pct    = 0;   // chance the receiver drops tready
  int hold_cycles  = 0;   // long receiver hold-off, counted down below
  int n_items      = 0;

  piecewise_linear_curve_lookup_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: random stalls, or a solid hold-off while hold_cycles runs down.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor: sampled values are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // One input transfer; tvalid stays high across back-to-back items.
  task automatic send_item(logic mode, logic [IDX_W-1:0] idx, logic [TENOR_W-1:0] tenor,
                           logic [RATE_W-1:0] rate, logic [TENOR_W-1:0] mat);
    int gap;
    gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {3'b0, mat, rate, tenor, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(mode, idx, tenor, rate, mat);
    n_items++;
  endtask

  task automatic load_node(int idx, int tenor, logic [RATE_W-1:0] rate);
    send_item(MODE_LOAD, IDX_W'(idx), TENOR_W'(tenor), rate, TENOR_W'($urandom));
  endtask

  task automatic query(int mat);
    send_item(MODE_QUERY, IDX_W'($urandom), TENOR_W'($urandom), $urandom, TENOR_W'(mat));
  endtask

  // Drain, then write entry_count while the block is idle.
  task automatic write_count(logic [CNT_W-1:0] v);
    s_axis_tvalid_i <= 1'b0;
    wait (sb.owed_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(v);
  endtask

  function automatic int pick_maturity();
    int k;
    k = $urandom_range(NODES - 1);
    case ($urandom_range(9))
      0:       return 0;
      1:       return 16'hFFFF;
      2, 3:    return sb.tenor_tab[k];
      4:       return (sb.tenor_tab[k] + 1) & 16'hFFFF;
      5:       return (sb.tenor_tab[k] - 1) & 16'hFFFF;
      6:       return $urandom_range(16'hFFFF);
      default: return $urandom_range(1, 50000);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] rate_value();
    if ($urandom_range(3) == 0) return $urandom;
    return RATE_W'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
  endfunction

  // Fresh curve: mostly increasing tenors, sometimes scrambled or misplaced.
  task automatic build_curve();
    int t;
    bit scrambled;
    scrambled = ($urandom_range(99) < 15);
    t = $urandom_range(0, 60);
    for (int i = 0; i < NODES; i++) begin
      if (scrambled || $urandom_range(99) < 4) load_node(i, $urandom, rate_value());
      else load_node(i, t, rate_value());
      t += $urandom_range(1, 1500);
    end
  endtask

  int counts [14] = '{32, 1, 2, 63, 17, 3, 33, 0, 8, 32, 5, 63, 2, 32};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty curve, then a four-node curve with extreme rates.
    query(0);
    query(16'hFFFF);
    load_node(31, 16'hFFFF, 32'h7FFF_FFFF);
    load_node(0, 10, 32'h8000_0000);
    load_node(1, 20, 32'h7FFF_FFFF);
    load_node(2, 30, 32'h0);
    load_node(3, 40, 32'hFFFF_FFFF);
    write_count(4);
    query(0);     // zero maturity
    query(5);     // flat below
    query(10);    // exact first node
    query(15);    // interpolated, rate spans full range
    query(25);    // interpolated, falling
    query(33);
    query(40);    // exact last node
    query(41);    // flat above
    query(16'hFFFF);

    // Random phases, each on a new curve and count, cycling idle patterns.
    for (int ph = 0; ph < 14; ph++) begin
      write_count(0);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 6; stall_pct = 6; end
      endcase
      build_curve();
      write_count(counts[ph]);
      if (ph == 2) hold_cycles = 400;   // back up the block behind a stuck sink
      for (int q = 0; q < 34; q++) begin
        if ($urandom_range(9) == 0) load_node($urandom_range(NODES - 1), $urandom, $urandom);
        else query(pick_maturity());
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait (sb.owed_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.owed_q.size() != 0) sb.errors++;

    $display("Covered %0d transfers over 15 curve settings, entry_count 0..63.", n_items);
    $display("Results: empty %0d zero %0d below %0d above %0d exact %0d interp %0d load %0d",
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_ZERO], sb.status_seen[ST_BELOW],
             sb.status_seen[ST_ABOVE], sb.status_seen[ST_EXACT], sb.status_seen[ST_INTERP],
             sb.status_seen[ST_LOADED]);
    if (sb.errors == 0) begin
      $display("piecewise_linear_curve_lookup_core_tb: done, clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("piecewise_linear_curve_lookup_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout");
    $display("piecewise_linear_curve_lookup_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: piecewise_linear_curve_lookup_core.f
rtl/plcl_pkg.sv
rtl/plcl_mem.sv
rtl/plcl_div.sv
rtl/piecewise_linear_curve_lookup_core.sv
tb/piecewise_linear_curve_lookup_core_tb.sv
